// ----- rtl/ptm_pkg.sv -----
package ptm_pkg;

  localparam int unsigned TableEntriesDef = 16;
  localparam int unsigned ValueBitsDef    = 32;

  localparam int unsigned PctBits   = 7;
  localparam int unsigned AlphaBits = 8;
  localparam int unsigned ProdBits  = 15;

  localparam logic [PctBits-1:0] PctFull = 7'd100;

  // x / 100 == (x * 5243) >> 19 for every x up to 255 * 100
  localparam int unsigned     RecipBits  = 13;
  localparam logic [12:0]     Recip      = 13'd5243;
  localparam int unsigned     RecipShift = 19;
  localparam int unsigned     MulBits    = ProdBits + RecipBits;

  typedef enum logic [2:0] {
    MODE_QRY_VAL   = 3'd0,
    MODE_QRY_COL   = 3'd1,
    MODE_APP_RANGE = 3'd2,
    MODE_APP_COL   = 3'd3,
    MODE_CLR_RANGE = 3'd4,
    MODE_CLR_COL   = 3'd5
  } mode_e;

  typedef struct packed {
    logic                 valid;
    mode_e                mode;
    logic [PctBits-1:0]   entry_pct;
    logic [AlphaBits-1:0] global_alpha;
    logic                 invalid;
    logic                 found;
    logic [PctBits-1:0]   hit_pct;
    logic                 rejected;
  } tok_t;

endpackage

// ----- rtl/ptm_if.sv -----
interface ptm_in_if #(
  parameter int unsigned VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   mode;
  logic signed [VALUE_BITS-1:0] value_a;
  logic signed [VALUE_BITS-1:0] value_b;
  logic signed [VALUE_BITS-1:0] value_c;
  logic [6:0]                   entry_percent;
  logic [7:0]                   global_alpha;
  logic                         sample_invalid;

  modport source (
    output valid, mode, value_a, value_b, value_c, entry_percent, global_alpha,
           sample_invalid,
    input  ready
  );
  modport sink (
    input  valid, mode, value_a, value_b, value_c, entry_percent, global_alpha,
           sample_invalid,
    output ready
  );
endinterface

interface ptm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] alpha;
  logic       matched;
  logic       append_rejected;

  modport source (
    output valid, alpha, matched, append_rejected,
    input  ready
  );
  modport sink (
    input  valid, alpha, matched, append_rejected,
    output ready
  );
endinterface

// ----- rtl/pixel_transparency_match.sv -----
// path: an accepted item passes the head register, the register of each cell and
// the scaler stages before it reaches the output, where its result can be taken
// throughput: one item per cycle; the whole cell chain and the two-stage alpha
// scaler advance in lockstep and hold together while a result waits to be taken
// reset: both entry counts go to zero and the pipeline empties; stored entries
// are undefined until appended
module pixel_transparency_match import ptm_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef,
  parameter int unsigned VALUE_BITS    = ValueBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptm_in_if.sink     in_i,
  ptm_out_if.source  out_o
);

  localparam int unsigned CNT_BITS = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_BITS-1:0] Full = CNT_BITS'(TABLE_ENTRIES);

  logic                adv, acc;
  mode_e               mode_in;
  logic [CNT_BITS-1:0] range_cnt_q, range_cnt_d, col_cnt_q, col_cnt_d, cnt_sel;
  tok_t                ctl0_d;

  tok_t                         ctl0_q;
  logic [CNT_BITS-1:0]          cnt0_q;
  logic signed [VALUE_BITS-1:0] a0_q, b0_q, c0_q;

  tok_t                         ctl_w [TABLE_ENTRIES+1];
  logic [CNT_BITS-1:0]          cnt_w [TABLE_ENTRIES+1];
  logic signed [VALUE_BITS-1:0] a_w   [TABLE_ENTRIES+1];
  logic signed [VALUE_BITS-1:0] b_w   [TABLE_ENTRIES+1];
  logic signed [VALUE_BITS-1:0] c_w   [TABLE_ENTRIES+1];

  assign adv        = !out_o.valid || out_o.ready;
  assign in_i.ready = adv;
  assign acc        = in_i.valid && adv;
  assign mode_in    = mode_e'(in_i.mode);

  // head: pick the table count, decide rejection, update counts
  always_comb begin
    range_cnt_d = range_cnt_q;
    col_cnt_d   = col_cnt_q;
    cnt_sel     = range_cnt_q;
    ctl0_d              = '0;
    ctl0_d.valid        = in_i.valid;
    ctl0_d.mode         = mode_in;
    ctl0_d.entry_pct    = in_i.entry_percent;
    ctl0_d.global_alpha = in_i.global_alpha;
    ctl0_d.invalid      = in_i.sample_invalid;
    unique case (mode_in)
      MODE_QRY_VAL: cnt_sel = range_cnt_q;
      MODE_QRY_COL: cnt_sel = col_cnt_q;
      MODE_APP_RANGE: begin
        cnt_sel = range_cnt_q;
        if (range_cnt_q >= Full) begin
          ctl0_d.rejected = 1'b1;
        end else if (acc) begin
          range_cnt_d = range_cnt_q + CNT_BITS'(1);
        end
      end
      MODE_APP_COL: begin
        cnt_sel = col_cnt_q;
        if (col_cnt_q >= Full) begin
          ctl0_d.rejected = 1'b1;
        end else if (acc) begin
          col_cnt_d = col_cnt_q + CNT_BITS'(1);
        end
      end
      MODE_CLR_RANGE: begin
        cnt_sel = Full;
        if (acc) begin
          range_cnt_d = '0;
        end
      end
      MODE_CLR_COL: begin
        cnt_sel = Full;
        if (acc) begin
          col_cnt_d = '0;
        end
      end
      default: cnt_sel = Full;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_cnt_q <= '0;
      col_cnt_q   <= '0;
      ctl0_q      <= '0;
    end else if (adv) begin
      range_cnt_q <= range_cnt_d;
      col_cnt_q   <= col_cnt_d;
      ctl0_q      <= ctl0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cnt0_q <= cnt_sel;
      a0_q   <= in_i.value_a;
      b0_q   <= in_i.value_b;
      c0_q   <= in_i.value_c;
    end
  end

  assign ctl_w[0] = ctl0_q;
  assign cnt_w[0] = cnt0_q;
  assign a_w[0]   = a0_q;
  assign b_w[0]   = b0_q;
  assign c_w[0]   = c0_q;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    ptm_cell #(
      .INDEX      (i),
      .VALUE_BITS (VALUE_BITS),
      .CNT_BITS   (CNT_BITS)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .ctl_i (ctl_w[i]),
      .cnt_i (cnt_w[i]),
      .a_i   (a_w[i]),
      .b_i   (b_w[i]),
      .c_i   (c_w[i]),
      .ctl_o (ctl_w[i+1]),
      .cnt_o (cnt_w[i+1]),
      .a_o   (a_w[i+1]),
      .b_o   (b_w[i+1]),
      .c_o   (c_w[i+1])
    );
  end

  ptm_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .ctl_i     (ctl_w[TABLE_ENTRIES]),
    .valid_o   (out_o.valid),
    .alpha_o   (out_o.alpha),
    .matched_o (out_o.matched),
    .rejected_o(out_o.append_rejected)
  );

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (range_cnt_q <= Full) && (col_cnt_q <= Full))
    else $error("entry count beyond table size");

  a_clr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (mode_in == MODE_CLR_RANGE) |=> range_cnt_q == '0)
    else $error("range clear did not empty the table");

  a_app_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (mode_in == MODE_APP_RANGE) && (range_cnt_q < Full)
    |=> range_cnt_q == ($past(range_cnt_q) + CNT_BITS'(1)))
    else $error("range append did not advance the count");

  a_rej_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.append_rejected |-> (out_o.alpha == '0) && !out_o.matched)
    else $error("rejected append beat carries query fields");

  a_held_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |=> (range_cnt_q == $past(range_cnt_q)) && (col_cnt_q == $past(col_cnt_q)))
    else $error("entry count moved without an accepted beat");

endmodule

// ----- rtl/ptm_cell.sv -----
module ptm_cell import ptm_pkg::*; #(
  parameter int unsigned INDEX      = 0,
  parameter int unsigned VALUE_BITS = ValueBitsDef,
  parameter int unsigned CNT_BITS   = 5
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  tok_t                         ctl_i,
  input  logic [CNT_BITS-1:0]          cnt_i,
  input  logic signed [VALUE_BITS-1:0] a_i,
  input  logic signed [VALUE_BITS-1:0] b_i,
  input  logic signed [VALUE_BITS-1:0] c_i,
  output tok_t                         ctl_o,
  output logic [CNT_BITS-1:0]          cnt_o,
  output logic signed [VALUE_BITS-1:0] a_o,
  output logic signed [VALUE_BITS-1:0] b_o,
  output logic signed [VALUE_BITS-1:0] c_o
);

  localparam logic [CNT_BITS-1:0] Idx = CNT_BITS'(INDEX);

  // stored entries of this cell
  logic signed [VALUE_BITS-1:0] rng_lo_q, rng_hi_q;
  logic [PctBits-1:0]           rng_pct_q;
  logic signed [VALUE_BITS-1:0] col_r_q, col_g_q, col_b_q;
  logic [PctBits-1:0]           col_pct_q;

  tok_t                         ctl_d, ctl_q;
  logic [CNT_BITS-1:0]          cnt_q;
  logic signed [VALUE_BITS-1:0] a_q, b_q, c_q;
  logic                         live, wr_here;

  assign live    = ctl_i.valid && !ctl_i.found && (Idx < cnt_i);
  assign wr_here = adv_i && ctl_i.valid && (cnt_i == Idx);

  always_comb begin
    ctl_d = ctl_i;
    if (live) begin
      case (ctl_i.mode)
        MODE_QRY_VAL: begin
          if ((a_i >= rng_lo_q) && (a_i <= rng_hi_q)) begin
            ctl_d.found   = 1'b1;
            ctl_d.hit_pct = rng_pct_q;
          end
        end
        MODE_QRY_COL: begin
          if ((a_i == col_r_q) && (b_i == col_g_q) && (c_i == col_b_q)) begin
            ctl_d.found   = 1'b1;
            ctl_d.hit_pct = col_pct_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_here && (ctl_i.mode == MODE_APP_RANGE)) begin
      rng_lo_q  <= a_i;
      rng_hi_q  <= b_i;
      rng_pct_q <= ctl_i.entry_pct;
    end
    if (wr_here && (ctl_i.mode == MODE_APP_COL)) begin
      col_r_q   <= a_i;
      col_g_q   <= b_i;
      col_b_q   <= c_i;
      col_pct_q <= ctl_i.entry_pct;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cnt_q <= cnt_i;
      a_q   <= a_i;
      b_q   <= b_i;
      c_q   <= c_i;
    end
  end

  assign ctl_o = ctl_q;
  assign cnt_o = cnt_q;
  assign a_o   = a_q;
  assign b_o   = b_q;
  assign c_o   = c_q;

endmodule

// ----- rtl/ptm_scale.sv -----
module ptm_scale import ptm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  tok_t                 ctl_i,
  output logic                 valid_o,
  output logic [AlphaBits-1:0] alpha_o,
  output logic                 matched_o,
  output logic                 rejected_o
);

  logic                 s1_valid_q, s1_matched_q, s1_rejected_q;
  logic [ProdBits-1:0]  prod_d, prod_q;
  logic                 matched_d, rejected_d;
  logic [MulBits-1:0]   mul;
  logic                 out_valid_q, out_matched_q, out_rejected_q;
  logic [AlphaBits-1:0] out_alpha_q;

  always_comb begin
    prod_d     = '0;
    matched_d  = 1'b0;
    rejected_d = 1'b0;
    case (ctl_i.mode) inside
      MODE_QRY_VAL, MODE_QRY_COL: begin
        if (!ctl_i.invalid) begin
          if (!ctl_i.found) begin
            prod_d = ProdBits'(ctl_i.global_alpha) * ProdBits'(PctFull);
          end else begin
            matched_d = 1'b1;
            if (ctl_i.hit_pct <= PctFull) begin
              prod_d = ProdBits'(ctl_i.global_alpha) * ProdBits'(PctFull - ctl_i.hit_pct);
            end
          end
        end
      end
      MODE_APP_RANGE, MODE_APP_COL: rejected_d = ctl_i.rejected;
      default: ;
    endcase
  end

  assign mul = MulBits'(prod_q) * MulBits'(Recip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q  <= ctl_i.valid;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q         <= prod_d;
      s1_matched_q   <= matched_d;
      s1_rejected_q  <= rejected_d;
      out_alpha_q    <= mul[RecipShift +: AlphaBits];
      out_matched_q  <= s1_matched_q;
      out_rejected_q <= s1_rejected_q;
    end
  end

  assign valid_o    = out_valid_q;
  assign alpha_o    = out_alpha_q;
  assign matched_o  = out_matched_q;
  assign rejected_o = out_rejected_q;

endmodule
